@@ rtl/peb_pkg.sv @@
// ----------------------------------------------------------------------------
// peb_pkg
// shared types and constants of the pin entry buffer
// ----------------------------------------------------------------------------
package peb_pkg;

    localparam int DEFAULT_MAX_DIGITS = 8;

    localparam int CNT_W  = 4;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 31;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 31'd30000;
    localparam logic [CFG_W-1:0] SHOW_RESET    = 31'd850;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // configuration register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_SHOW    = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [7:0]        key_char;
        logic [TIME_W-1:0] now_time;
        logic [3:0]        query_index;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] timeout_ms;
        logic [CFG_W-1:0] show_ms;
    } cfg_t;

endpackage

@@ rtl/peb_core.sv @@
// ----------------------------------------------------------------------------
// peb_core
// digit stack state, update per item and registered result
// ----------------------------------------------------------------------------
module peb_core
    import peb_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  item_t            item,
    input  cfg_t             cfg,
    output logic             done,
    output logic             accepted,
    output logic [CNT_W-1:0] entry_length,
    output logic             is_timed_out,
    output logic [7:0]       digit_char,
    output logic             digit_shown
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    logic [3:0]        digit_reg [MAX_DIGITS];
    logic [3:0]        digit_next [MAX_DIGITS];
    logic [TIME_W-1:0] until_reg [MAX_DIGITS];
    logic [TIME_W-1:0] until_next [MAX_DIGITS];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] last_reg, last_next;

    logic              done_reg;
    logic              accepted_reg, accepted_next;
    logic              timed_reg, timed_next;
    logic [7:0]        char_reg, char_next;
    logic              shown_reg, shown_next;

    logic [IDX_W-1:0]  push_ptr;
    logic [IDX_W-1:0]  query_ptr;
    logic [7:0]        key_off;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] remain;

    assign push_ptr  = count_reg[IDX_W-1:0];
    assign query_ptr = item.query_index[IDX_W-1:0];
    assign key_off   = item.key_char - CHAR_ZERO;

    always_comb
    begin
        digit_next    = digit_reg;
        until_next    = until_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        accepted_next = 1'b0;
        if (item_valid)
        begin
            case (item.cmd)
                CMD_CLEAR:
                begin
                    // entries above the count are never read, so only the count and last activity are wiped
                    count_next    = '0;
                    last_next     = '0;
                    accepted_next = 1'b1;
                end
                CMD_APPEND:
                begin
                    if (count_reg < MAX_CNT && (item.key_char inside {[CHAR_ZERO:CHAR_NINE]}))
                    begin
                        digit_next[push_ptr] = key_off[3:0];
                        until_next[push_ptr] = item.now_time + {1'b0, cfg.show_ms};
                        count_next           = count_reg + 1'b1;
                        last_next            = item.now_time;
                        accepted_next        = 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next    = count_reg - 1'b1;
                        last_next     = item.now_time;
                        accepted_next = 1'b1;
                    end
                end
                default:
                begin
                    accepted_next = 1'b0;
                end
            endcase
        end
    end

    // results are taken from the state after this item
    always_comb
    begin
        elapsed    = item.now_time - last_next;
        timed_next = (last_next != '0) && !elapsed[TIME_W-1]
                     && (elapsed[CFG_W-1:0] >= cfg.timeout_ms);
        remain     = until_next[query_ptr] - item.now_time;
        char_next  = 8'd0;
        shown_next = 1'b0;
        if (item.query_index < count_next)
        begin
            char_next  = CHAR_ZERO + {4'd0, digit_next[query_ptr]};
            shown_next = !remain[TIME_W-1] && (remain != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
            done_reg  <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg    <= digit_next;
        until_reg    <= until_next;
        accepted_reg <= accepted_next;
        timed_reg    <= timed_next;
        char_reg     <= char_next;
        shown_reg    <= shown_next;
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign entry_length = count_reg;
    assign is_timed_out = timed_reg;
    assign digit_char   = char_reg;
    assign digit_shown  = shown_reg;

endmodule

@@ rtl/pin_entry_buffer.sv @@
// ----------------------------------------------------------------------------
// pin_entry_buffer
// keypad pin entry stack with inactivity timeout and digit visibility window
// ----------------------------------------------------------------------------
// result strobe done follows start through the input register, then the
//   state update and result register
// throughput: one item every cycle; busy is always low
// reset: digit count and last activity cleared, timeout 30000, show 850
// the receiver cannot stall; each result is valid for one cycle only
// ----------------------------------------------------------------------------
module pin_entry_buffer
    import peb_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       cmd,
    input  logic [7:0]       key_char,
    input  logic [31:0]      now_time,
    input  logic [3:0]       query_index,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [CFG_W-1:0] wr_data,
    output logic             done,
    output logic             accepted,
    output logic [CNT_W-1:0] entry_length,
    output logic             is_timed_out,
    output logic [7:0]       digit_char,
    output logic             digit_shown
);

    item_t item_reg;
    logic  item_valid_reg;
    cfg_t  cfg_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            cfg_reg.timeout_ms <= TIMEOUT_RESET;
            cfg_reg.show_ms    <= SHOW_RESET;
        end
        else
        begin
            item_valid_reg <= start && !busy;
            if (wr_en)
            begin
                case (wr_index)
                    REG_TIMEOUT: cfg_reg.timeout_ms <= wr_data;
                    REG_SHOW:    cfg_reg.show_ms    <= wr_data;
                    default:     cfg_reg            <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg.cmd         <= cmd_t'(cmd);
            item_reg.key_char    <= key_char;
            item_reg.now_time    <= now_time;
            item_reg.query_index <= query_index;
        end
    end

    peb_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .cfg          (cfg_reg),
        .done         (done),
        .accepted     (accepted),
        .entry_length (entry_length),
        .is_timed_out (is_timed_out),
        .digit_char   (digit_char),
        .digit_shown  (digit_shown)
    );

endmodule

@@ test/pin_entry_checker.sv @@
// ----------------------------------------------------------------------------
// pin_entry_checker
// watches the item, register and readout ports of the pin entry buffer,
// keeps its own copy of the digit stack and compares every readout
// ----------------------------------------------------------------------------
module pin_entry_checker
    import peb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       cmd,
    input  logic [7:0]       key_char,
    input  logic [31:0]      now_time,
    input  logic [3:0]       query_index,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [CFG_W-1:0] wr_data,
    input  logic             done,
    input  logic             accepted,
    input  logic [CNT_W-1:0] entry_length,
    input  logic             is_timed_out,
    input  logic [7:0]       digit_char,
    input  logic             digit_shown,
    output int               fail_count,
    output int               pending,
    output int               compared
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] length;
        logic             expired;
        logic [7:0]       digit;
        logic             shown;
    } readout_t;

    logic [3:0]        slot_digit      [DEFAULT_MAX_DIGITS];
    logic [TIME_W-1:0] slot_show_until [DEFAULT_MAX_DIGITS];
    logic [CNT_W-1:0]  stored;
    logic [TIME_W-1:0] last_touch;
    logic [CFG_W-1:0]  timeout_ms;
    logic [CFG_W-1:0]  show_ms;

    readout_t readouts_due[$];
    int       errors;
    int       n_compared;

    function automatic void wipe_stack_copy();
        for (int i = 0; i < DEFAULT_MAX_DIGITS; i++)
        begin
            slot_digit[i]      = '0;
            slot_show_until[i] = '0;
        end
        stored     = '0;
        last_touch = '0;
    endfunction

    // applies one item to the stack copy and returns the readout it gives
    function automatic readout_t predict_entry_readout(cmd_t op, logic [7:0] key,
                                                       logic [TIME_W-1:0] now,
                                                       logic [3:0] qi);
        readout_t          r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] window;
        r = '0;
        case (op)
            CMD_CLEAR:
            begin
                wipe_stack_copy();
                r.accepted = 1'b1;
            end
            CMD_APPEND:
            begin
                if (stored < DEFAULT_MAX_DIGITS && key >= CHAR_ZERO && key <= CHAR_NINE)
                begin
                    slot_digit[stored]      = 4'(key - CHAR_ZERO);
                    slot_show_until[stored] = now + {1'b0, show_ms};
                    stored                  = stored + 1'b1;
                    last_touch              = now;
                    r.accepted              = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (stored != 0)
                begin
                    stored                  = stored - 1'b1;
                    slot_digit[stored]      = '0;
                    slot_show_until[stored] = '0;
                    last_touch              = now;
                    r.accepted              = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // zero last activity means idle; elapsed time is read as signed
        if (last_touch != 0)
        begin
            elapsed = now - last_touch;
            if (!elapsed[TIME_W-1] && elapsed >= {1'b0, timeout_ms})
                r.expired = 1'b1;
        end

        if (qi < stored)
        begin
            window  = slot_show_until[qi] - now;
            r.digit = CHAR_ZERO + slot_digit[qi];
            r.shown = !window[TIME_W-1] && window != 0;
        end
        r.length = stored;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        readout_t want;
        if (!rst_n)
        begin
            wipe_stack_copy();
            timeout_ms = TIMEOUT_RESET;
            show_ms    = SHOW_RESET;
            readouts_due.delete();
            errors     = 0;
            n_compared = 0;
            fail_count <= 0;
            pending    <= 0;
            compared   <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_TIMEOUT: timeout_ms = wr_data;
                    REG_SHOW:    show_ms    = wr_data;
                    default:     ;
                endcase
            end

            if (done)
            begin
                if (readouts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: readout with no item waiting, length %0d digit %0d",
                             $time, entry_length, digit_char);
                end
                else
                begin
                    want = readouts_due.pop_front();
                    n_compared++;
                    check_field("accepted", want.accepted, accepted);
                    check_field("entry_length", want.length, entry_length);
                    check_field("is_timed_out", want.expired, is_timed_out);
                    check_field("digit_char", want.digit, digit_char);
                    check_field("digit_shown", want.shown, digit_shown);
                end
            end

            if (start && !busy)
                readouts_due.push_back(predict_entry_readout(cmd_t'(cmd), key_char,
                                                             now_time, query_index));

            fail_count <= errors;
            pending    <= readouts_due.size();
            compared   <= n_compared;
        end
    end

endmodule

@@ test/pin_entry_buffer_tb.sv @@
// ----------------------------------------------------------------------------
// pin_entry_buffer_tb
// drives keypad items and register settings into the pin entry buffer; a
// checker beside the block predicts each readout and counts mismatches
// ----------------------------------------------------------------------------
module pin_entry_buffer_tb
    import peb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 180;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    cmd_t             cmd         = CMD_QUERY;
    logic [7:0]       key_char    = '0;
    logic [31:0]      now_time    = '0;
    logic [3:0]       query_index = '0;
    logic             wr_en       = 1'b0;
    logic             wr_index    = REG_TIMEOUT;
    logic [CFG_W-1:0] wr_data     = '0;
    logic             done;
    logic             accepted;
    logic [CNT_W-1:0] entry_length;
    logic             is_timed_out;
    logic [7:0]       digit_char;
    logic             digit_shown;

    int fail_count;
    int pending;
    int compared;
    int cycle_count   = 0;
    int items_sent    = 0;
    int settings_used = 1;

    logic [31:0] wall_ms = '0;
    bit          idle_on = 1'b0;

    pin_entry_buffer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .key_char     (key_char),
        .now_time     (now_time),
        .query_index  (query_index),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .accepted     (accepted),
        .entry_length (entry_length),
        .is_timed_out (is_timed_out),
        .digit_char   (digit_char),
        .digit_shown  (digit_shown)
    );

    pin_entry_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .key_char     (key_char),
        .now_time     (now_time),
        .query_index  (query_index),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .accepted     (accepted),
        .entry_length (entry_length),
        .is_timed_out (is_timed_out),
        .digit_char   (digit_char),
        .digit_shown  (digit_shown),
        .fail_count   (fail_count),
        .pending      (pending),
        .compared     (compared)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit with %0d readouts outstanding", pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // start is left high so the next item can follow in the very next cycle
    task automatic send_item(cmd_t c, logic [7:0] k, logic [31:0] t, logic [3:0] q);
        cmd         <= c;
        key_char    <= k;
        now_time    <= t;
        query_index <= q;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] t_ms, logic [CFG_W-1:0] s_ms);
        wr_en    <= 1'b1;
        wr_index <= REG_TIMEOUT;
        wr_data  <= t_ms;
        @(posedge clk);
        wr_index <= REG_SHOW;
        wr_data  <= s_ms;
        @(posedge clk);
        wr_en    <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic send_random_item();
        int         pick;
        int         step;
        cmd_t       c;
        logic [7:0] k;
        logic [3:0] q;
        pick = $urandom_range(0, 99);
        step = $urandom_range(0, 99);
        // mostly small steps, some past the timeout, a few arbitrary jumps
        if (step < 55)
            wall_ms = wall_ms + $urandom_range(0, 40);
        else if (step < 85)
            wall_ms = wall_ms + $urandom_range(0, 40000);
        else if (step < 97)
            wall_ms = $urandom;
        else
            wall_ms = '0;
        k = 8'($urandom_range(0, 255));
        if (pick < 40)
        begin
            c = CMD_APPEND;
            k = CHAR_ZERO + 8'($urandom_range(0, 9));
        end
        else if (pick < 50)
            c = CMD_APPEND;
        else if (pick < 70)
            c = CMD_DELETE;
        else if (pick < 95)
            c = CMD_QUERY;
        else
            c = CMD_CLEAR;
        if ($urandom_range(0, 9) < 7)
            q = 4'($urandom_range(0, 8));
        else
            q = 4'($urandom_range(0, 15));
        send_item(c, k, wall_ms, q);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset settings
        send_item(CMD_QUERY,  8'h00, 32'h0000_0000, 4'd0);
        send_item(CMD_QUERY,  8'hFF, 32'hFFFF_FFFF, 4'd15);
        send_item(CMD_DELETE, 8'h00, 32'd5,         4'd0);
        // activity at time zero reads as idle
        send_item(CMD_APPEND, CHAR_ZERO, 32'd0,     4'd0);
        send_item(CMD_APPEND, 8'h2F, 32'd10,        4'd0);
        send_item(CMD_APPEND, 8'h3A, 32'd11,        4'd0);
        send_item(CMD_APPEND, 8'hFF, 32'd12,        4'd0);
        send_item(CMD_APPEND, 8'h00, 32'd13,        4'd0);
        send_item(CMD_APPEND, CHAR_NINE, 32'd20,    4'd1);
        for (int i = 1; i <= 6; i++)
            send_item(CMD_APPEND, CHAR_ZERO + 8'(i), 32'(20 + 10 * i), 4'(i + 1));
        // stack full, append refused
        send_item(CMD_APPEND, 8'h37, 32'd90,        4'd7);
        send_item(CMD_QUERY,  8'h00, 32'd900,       4'd7);
        send_item(CMD_QUERY,  8'h00, 32'd901,       4'd8);
        send_item(CMD_QUERY,  8'h00, 32'd30080,     4'd0);
        send_item(CMD_DELETE, 8'h00, 32'd30100,     4'd6);
        send_item(CMD_CLEAR,  8'h00, 32'd30200,     4'd0);
        // show window wraps past zero
        send_item(CMD_APPEND, 8'h35, 32'hFFFF_FF00, 4'd0);
        send_item(CMD_QUERY,  8'h00, 32'h0000_0010, 4'd0);
        send_item(CMD_QUERY,  8'h00, 32'h7FFF_FF00, 4'd0);
        send_item(CMD_DELETE, 8'h00, 32'h0000_0000, 4'd0);
        send_item(CMD_QUERY,  8'h00, 32'd12345,     4'd0);
        wall_ms = 32'd40000;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                case (phase)
                    1:       program_regs('0, '0);
                    2:       program_regs('1, '1);
                    3:       program_regs(31'($urandom_range(1, 4000)),
                                          31'($urandom_range(1, 2000)));
                    default: program_regs(31'($urandom), 31'($urandom));
                endcase
            end
            if (phase == 2)
            begin
                // largest timeout is reached only at the largest forward distance
                send_item(CMD_APPEND, 8'h33, 32'h1234_5678, 4'd0);
                send_item(CMD_QUERY,  8'h00, 32'h1234_5678 + 32'h7FFF_FFFE, 4'd0);
                send_item(CMD_QUERY,  8'h00, 32'h1234_5678 + 32'h7FFF_FFFF, 4'd0);
                send_item(CMD_CLEAR,  8'h00, 32'h1234_5679, 4'd0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    idle_on = (phase != PHASES - 1) && ($urandom_range(0, 1) == 1);
                send_random_item();
                if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge clk);
                end
            end
        end

        drain();
        repeat (6) @(posedge clk);
        $display("covered %0d keypad items under %0d register settings, %0d readouts compared",
                 items_sent, settings_used, compared);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ pin_entry_buffer.f @@
rtl/peb_pkg.sv
rtl/peb_core.sv
rtl/pin_entry_buffer.sv
test/pin_entry_checker.sv
test/pin_entry_buffer_tb.sv
